// ===== sv/csa_pkg.sv =====
package csa_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_SEEK = 2'd1,
    ACT_MAIN = 2'd2,
    ACT_SUB  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_AUDIO = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_MSF_A,
    ST_MSF_B,
    ST_MSF_C,
    ST_MSF_D,
    ST_SEEK_OUT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  entry_slot;
    logic [19:0] entry_pregap_len;
    logic [19:0] entry_start;
    logic [19:0] entry_end;
    logic [31:0] entry_file_base;
    logic [11:0] entry_sector_size;
    logic [2:0]  entry_flags;
    logic [3:0]  entry_file_id;
    logic [19:0] sector_number;
    logic [11:0] byte_offset;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  seek_track;
    logic [7:0]  byte_value;
    logic        from_file;
    logic [3:0]  fetch_file;
    logic [31:0] fetch_address;
  } out_word_t;

  typedef struct packed {
    logic [19:0] pregap;
    logic [19:0] start;
    logic [19:0] fin;
  } bounds_t;

  typedef struct packed {
    logic [31:0] base;
    logic [11:0] size;
    logic [2:0]  flags;
    logic [3:0]  file;
  } layout_t;

  localparam int FLAG_DATA = 0;
  localparam int FLAG_SUB  = 1;
  localparam int FLAG_SWAP = 2;

  // reciprocal constants: exact for 20-bit sector and 14-bit minute-second count
  localparam logic [19:0] RECIP_75  = 20'd894785;  // 2^26 / 75, rounded up
  localparam int          SHIFT_75  = 26;
  localparam logic [14:0] RECIP_60  = 15'd17477;   // 2^20 / 60, rounded up
  localparam int          SHIFT_60  = 20;
  localparam logic [11:0] RAW_SECTOR = 12'd2352;
  localparam logic [11:0] SUB_BYTES  = 12'd96;
  localparam logic [11:0] HDR_BYTES  = 12'd16;
  localparam logic [11:0] HDR_MODE   = 12'd15;
  localparam logic [11:0] HDR_MIN    = 12'd12;
  localparam logic [11:0] HDR_SEC    = 12'd13;
  localparam logic [11:0] HDR_FRM    = 12'd14;
  localparam logic [11:0] SYNC_END   = 12'd11;

  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] p;
    logic [7:0]  tens;
    logic [7:0]  ones;
    p    = 16'(v) * 16'd205;
    tens = 8'(p >> 11);
    ones = 8'(v - 8'(tens * 8'd10));
    return {tens[3:0], ones[3:0]};
  endfunction

  // sync pattern and MSF/mode header of a synthesized sector
  function automatic logic [7:0] hdr_byte(input logic [11:0] off, input logic [7:0] m,
                                          input logic [7:0] s, input logic [7:0] f);
    logic [7:0] b;
    if (off == 12'd0 || off == SYNC_END || off >= HDR_BYTES) b = 8'h00;
    else if (off < SYNC_END) b = 8'hFF;
    else if (off == HDR_MIN) b = m;
    else if (off == HDR_SEC) b = s;
    else if (off == HDR_FRM) b = f;
    else b = 8'h01;
    return b;
  endfunction

endpackage

// ===== sv/csa_ram.sv =====
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/cd_image_sector_access.sv =====
// CD image sector access. Load track entries (no result word), then seek to
// an absolute sector and read main or subcode bytes; each seek gives one
// result word with the track index the walk ended on, and each read one
// telling either the byte to synthesize or which image file and byte
// address to fetch. The track table sits in two RAMs with a registered read;
// entries are undefined until loaded. A load leaves the input free. A read
// does one RAM read of the current track, then gives the result. A seek
// walks the table, reading one entry per cycle from the bounds RAM until an
// entry matches or the track count, clipped to 0 to MAX_TRACKS, is used up;
// then the multiply steps ST_MSF_A to ST_MSF_D build the MSF header bytes
// and the image pointers, and ST_SEEK_OUT loads the output register. Output
// stalls hold the step that loads the output register, for seeks and reads.
// The input stalls while an item is in work; a finished result waits in the
// output register and the next word can be taken meanwhile. track_count may
// only be written while idle.
module cd_image_sector_access #(
  parameter int MAX_TRACKS = 128,
  parameter int FILE_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  csa_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output csa_pkg::out_word_t  out_word
);
  import csa_pkg::*;

  localparam int IDXW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int KW   = $clog2(MAX_TRACKS + 1);

  // slot and file id reduction tables, built at elaboration
  function automatic logic [128*IDXW-1:0] slot_map_f();
    logic [128*IDXW-1:0] m;
    m = '0;
    for (int i = 0; i < 128; i++) m[i*IDXW +: IDXW] = IDXW'(i % MAX_TRACKS);
    return m;
  endfunction

  function automatic logic [63:0] file_map_f();
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) m[i*4 +: 4] = 4'(i % FILE_COUNT);
    return m;
  endfunction

  localparam logic [128*IDXW-1:0] SlotMap = slot_map_f();
  localparam logic [63:0]         FileMap = file_map_f();

  state_t      state_r, state_nxt;
  logic [7:0]  track_count_r;
  logic [19:0] pos_sector_r, pos_sector_nxt;
  logic [IDXW-1:0] pos_track_r, pos_track_nxt;
  kind_t       kind_r, kind_nxt;
  logic [31:0] read_ptr_r, read_ptr_nxt;
  logic [31:0] sub_base_r, sub_base_nxt;
  logic [31:0] held_addr_r, held_addr_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [19:0] lba_r, lba_nxt;
  logic [19:0] prev_end_r, prev_end_nxt;
  logic        pos_upd_r, pos_upd_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [13:0] q75_r, q75_nxt;
  logic [6:0]  frm_r, frm_nxt;
  logic [7:0]  q60_r, q60_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [7:0]  min_bcd_r, min_bcd_nxt;
  logic [7:0]  sec_bcd_r, sec_bcd_nxt;
  logic [7:0]  frm_bcd_r, frm_bcd_nxt;
  logic        sub_act_r, sub_act_nxt;
  logic [11:0] off_r, off_nxt;
  logic [IDXW-1:0] rd_addr_r, rd_addr_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic        tbl_we;
  logic [IDXW-1:0] tbl_waddr;
  bounds_t     bnd_w, bnd_q;
  layout_t     lay_w, lay_q;

  logic        accept, out_free;
  logic [KW-1:0] n_lim;
  logic [19:0] lba_rem;
  kind_t       kind_k;
  logic [39:0] mul75;
  logic [28:0] mul60;
  logic [31:0] rel;
  logic [3:0]  file_q;

  assign bnd_w = '{pregap: in_word.entry_pregap_len, start: in_word.entry_start,
                   fin: in_word.entry_end};
  assign lay_w = '{base: in_word.entry_file_base, size: in_word.entry_sector_size,
                   flags: in_word.entry_flags, file: in_word.entry_file_id};
  assign tbl_waddr = SlotMap[in_word.entry_slot*IDXW +: IDXW];
  assign tbl_we    = accept && (in_word.action == ACT_LOAD);

  csa_ram #(.WIDTH($bits(bounds_t)), .DEPTH(MAX_TRACKS)) u_bounds (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (bnd_w),
    .rd_addr (rd_addr_nxt),
    .rd_data (bnd_q)
  );

  csa_ram #(.WIDTH($bits(layout_t)), .DEPTH(MAX_TRACKS)) u_layout (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (lay_w),
    .rd_addr (rd_addr_nxt),
    .rd_data (lay_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // walk limit: table count clipped to the table depth
  assign n_lim   = (32'(track_count_r) < MAX_TRACKS) ? KW'(track_count_r) : KW'(MAX_TRACKS);
  assign lba_rem = lba_r - bnd_q.pregap;
  assign kind_k  = lay_q.flags[FLAG_DATA] ? KIND_DATA : KIND_AUDIO;
  assign mul75   = 40'(pos_sector_r) * 40'(RECIP_75);
  assign mul60   = 29'(q75_r) * 29'(RECIP_60);
  assign rel     = 32'(lba_r) - 32'(prev_end_r);  // may wrap, as the address math does
  assign file_q  = FileMap[lay_q.file*4 +: 4];

  always_comb begin
    state_nxt      = state_r;
    pos_sector_nxt = pos_sector_r;
    pos_track_nxt  = pos_track_r;
    kind_nxt       = kind_r;
    read_ptr_nxt   = read_ptr_r;
    sub_base_nxt   = sub_base_r;
    held_addr_nxt  = held_addr_r;
    k_nxt          = k_r;
    lba_nxt        = lba_r;
    prev_end_nxt   = prev_end_r;
    pos_upd_nxt    = pos_upd_r;
    prod_nxt       = prod_r;
    q75_nxt        = q75_r;
    frm_nxt        = frm_r;
    q60_nxt        = q60_r;
    sec_nxt        = sec_r;
    min_bcd_nxt    = min_bcd_r;
    sec_bcd_nxt    = sec_bcd_r;
    frm_bcd_nxt    = frm_bcd_r;
    sub_act_nxt    = sub_act_r;
    off_nxt        = off_r;
    rd_addr_nxt    = rd_addr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (action_t'(in_word.action))
            ACT_LOAD: ;
            ACT_SEEK: begin
              pos_sector_nxt = in_word.sector_number;
              lba_nxt        = in_word.sector_number;
              prev_end_nxt   = '0;
              k_nxt          = '0;
              pos_upd_nxt    = 1'b0;
              rd_addr_nxt    = '0;
              state_nxt      = ST_SEEK;
            end
            ACT_MAIN, ACT_SUB: begin
              sub_act_nxt = (in_word.action == ACT_SUB);
              off_nxt     = in_word.byte_offset;
              rd_addr_nxt = pos_track_r;
              state_nxt   = ST_READ;
            end
            default: ;
          endcase
        end
      end

      // one table entry per cycle; entry k_r is on the RAM outputs
      ST_SEEK: begin
        if (k_r >= n_lim) begin
          state_nxt = ST_MSF_A;
        end else if (lba_r < bnd_q.pregap) begin
          pos_track_nxt = k_r[IDXW-1:0];
          kind_nxt      = kind_k;
          state_nxt     = ST_MSF_A;
        end else if (lba_rem < bnd_q.start) begin
          pos_track_nxt = k_r[IDXW-1:0];
          kind_nxt      = (bnd_q.pregap != '0) ? kind_k : KIND_NONE;
          pos_upd_nxt   = (bnd_q.pregap == '0);
          lba_nxt       = lba_rem;
          state_nxt     = ST_MSF_A;
        end else if (lba_rem < bnd_q.fin) begin
          pos_track_nxt = k_r[IDXW-1:0];
          kind_nxt      = KIND_NONE;
          pos_upd_nxt   = 1'b1;
          lba_nxt       = lba_rem;
          state_nxt     = ST_MSF_A;
        end else begin
          lba_nxt      = lba_rem;
          prev_end_nxt = bnd_q.fin;
          k_nxt        = k_r + 1'b1;
          rd_addr_nxt  = k_nxt[IDXW-1:0];
        end
      end

      ST_MSF_A: begin
        q75_nxt   = 14'(mul75 >> SHIFT_75);
        prod_nxt  = 32'(rel * 32'(lay_q.size));
        state_nxt = ST_MSF_B;
      end

      ST_MSF_B: begin
        frm_nxt   = 7'(pos_sector_r - 20'(20'(q75_r) * 20'd75));
        q60_nxt   = 8'(mul60 >> SHIFT_60);
        if (pos_upd_r) begin
          read_ptr_nxt = lay_q.base + prod_r;
          if (lay_q.flags[FLAG_SUB]) begin
            sub_base_nxt = lay_q.base + prod_r + 32'(lay_q.size) - 32'(SUB_BYTES);
          end
        end
        state_nxt = ST_MSF_C;
      end

      ST_MSF_C: begin
        sec_nxt   = 6'(q75_r - 14'(14'(q60_r) * 14'd60));
        state_nxt = ST_MSF_D;
      end

      ST_MSF_D: begin
        min_bcd_nxt = to_bcd(q60_r);
        sec_bcd_nxt = to_bcd(8'(sec_r));
        frm_bcd_nxt = to_bcd(8'(frm_r));
        state_nxt   = ST_SEEK_OUT;
      end

      ST_SEEK_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          out_word_nxt.seek_track = 8'(k_r);
          state_nxt     = ST_IDLE;
        end
      end

      // layout of the current track is on the RAM output
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          out_word_nxt.seek_track = 8'(pos_track_r);
          if (sub_act_r) begin
            if (kind_r == KIND_NONE && lay_q.flags[FLAG_SUB] && off_r < SUB_BYTES) begin
              out_word_nxt.from_file     = 1'b1;
              out_word_nxt.fetch_file    = file_q;
              out_word_nxt.fetch_address = sub_base_r + 32'(off_r);
            end
          end else if (kind_r == KIND_DATA) begin
            out_word_nxt.byte_value = hdr_byte(off_r, min_bcd_r, sec_bcd_r, frm_bcd_r);
          end else if (kind_r == KIND_AUDIO) begin
            out_word_nxt.byte_value = 8'h00;
          end else if ((lay_q.size < RAW_SECTOR && off_r < HDR_BYTES) ||
                       (13'(off_r) > 13'(lay_q.size) + 13'(HDR_BYTES))) begin
            out_word_nxt.byte_value = hdr_byte(off_r, min_bcd_r, sec_bcd_r, frm_bcd_r);
          end else begin
            out_word_nxt.from_file  = 1'b1;
            out_word_nxt.fetch_file = file_q;
            if (lay_q.flags[FLAG_SWAP]) begin
              // pairs reversed: even offset takes the second byte, odd the held first
              if (off_r[0]) begin
                out_word_nxt.fetch_address = held_addr_r;
              end else begin
                held_addr_nxt = read_ptr_r;
                out_word_nxt.fetch_address = read_ptr_r + 32'd1;
                read_ptr_nxt  = read_ptr_r + 32'd2;
              end
            end else begin
              out_word_nxt.fetch_address = read_ptr_r;
              read_ptr_nxt  = read_ptr_r + 32'd1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      track_count_r <= '0;
      pos_sector_r  <= '0;
      pos_track_r   <= '0;
      kind_r        <= KIND_NONE;
      read_ptr_r    <= '0;
      sub_base_r    <= '0;
      held_addr_r   <= '0;
      min_bcd_r     <= '0;
      sec_bcd_r     <= '0;
      frm_bcd_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_wr_en) begin
        track_count_r <= cfg_wr_data;
      end
      pos_sector_r  <= pos_sector_nxt;
      pos_track_r   <= pos_track_nxt;
      kind_r        <= kind_nxt;
      read_ptr_r    <= read_ptr_nxt;
      sub_base_r    <= sub_base_nxt;
      held_addr_r   <= held_addr_nxt;
      min_bcd_r     <= min_bcd_nxt;
      sec_bcd_r     <= sec_bcd_nxt;
      frm_bcd_r     <= frm_bcd_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    lba_r      <= lba_nxt;
    prev_end_r <= prev_end_nxt;
    pos_upd_r  <= pos_upd_nxt;
    prod_r     <= prod_nxt;
    q75_r      <= q75_nxt;
    frm_r      <= frm_nxt;
    q60_r      <= q60_nxt;
    sec_r      <= sec_nxt;
    sub_act_r  <= sub_act_nxt;
    off_r      <= off_nxt;
    rd_addr_r  <= rd_addr_nxt;
    out_word_r <= out_word_nxt;
  end

`ifndef SYNTH
  // a table load never yields a result word
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.action == ACT_LOAD) |=> !$rose(out_valid_r))
    else $error("load produced a result");

  // fetch words carry no synthesized byte
  a_fetch_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.from_file) |-> (out_word_r.byte_value == 8'h00))
    else $error("fetch word with nonzero byte value");

  // synthesized words carry no fetch location
  a_synth_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.from_file) |->
      (out_word_r.fetch_address == '0 && out_word_r.fetch_file == '0))
    else $error("synthesized word with fetch location");

  // the walk never passes the clipped track count
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEEK) |-> (k_r <= n_lim))
    else $error("seek walked past the table");
`endif

endmodule
